### design/spq_pkg.sv
`default_nettype none
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int TAG_W = 16;
	localparam int SCORE_W = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED = 2'd1,
		ST_POP_EMPTY = 2'd2,
		ST_INSERT_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
		entry_t entry;
	} ctl_t;

endpackage
`default_nettype wire

### design/spq_cell.sv
`default_nettype none
module spq_cell (
	input wire logic clk,
	input wire spq_pkg::ctl_t ctl,
	input wire logic occupied,
	input wire spq_pkg::entry_t prev_entry,
	input wire logic prev_after,
	input wire spq_pkg::entry_t next_entry,
	output spq_pkg::entry_t entry,
	output logic after
);

	spq_pkg::entry_t entry_q;

	// The new item belongs in front of this cell when the cell is empty or holds a lower score.
	assign after = !occupied || (entry_q.score < ctl.entry.score);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (after && !prev_after) begin
				entry_q <= ctl.entry;
			end else if (after) begin
				entry_q <= prev_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

### design/sorted_priority_queue.sv
// Sorted priority queue of spq_pkg::CAPACITY entries held in a row of cells in descending
// score order, with equal scores kept in arrival order. Every cell compares its score with
// an incoming entry in parallel, so an insert or a pop is applied when accepted and an item
// can be accepted in every cycle. The result is held in an output register; a new item is
// accepted while that register is empty or its result is being taken in the same cycle.
// Inserts into a full queue are dropped and reported; pops on an empty queue are reported.
`default_nettype none
module sorted_priority_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire logic [0:0] operation,
	input wire logic signed [31:0] item_score,
	input wire logic [15:0] item_tag,
	output logic result_valid,
	input wire logic result_ready,
	output logic [1:0] status,
	output logic signed [31:0] popped_score,
	output logic [15:0] popped_tag,
	output logic [4:0] entry_total
);

	localparam int N = spq_pkg::CAPACITY;
	localparam int CW = spq_pkg::CNT_W;

	logic [CW-1:0] count_q;
	logic result_valid_q;
	spq_pkg::status_t status_q;
	spq_pkg::entry_t popped_q;
	logic [CW-1:0] total_q;

	logic accept;
	logic is_pop;
	logic full;
	logic empty;
	spq_pkg::ctl_t ctl;
	logic [N-1:0] occ;
	logic [N-1:0] after;
	spq_pkg::entry_t cell_entry [N];
	spq_pkg::status_t status_d;
	logic [CW-1:0] count_d;

	assign item_ready = !result_valid_q || result_ready;
	assign accept = item_valid && item_ready;
	assign is_pop = (spq_pkg::op_t'(operation) == spq_pkg::OP_POP);
	assign full = (count_q == CW'(N));
	assign empty = (count_q == '0);

	always_comb begin
		ctl.insert = accept && !is_pop && !full;
		ctl.pop = accept && is_pop && !empty;
		ctl.entry.score = item_score;
		ctl.entry.tag = item_tag;
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		assign occ[g] = (count_q > CW'(g));
		spq_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.occupied(occ[g]),
			.prev_entry((g == 0) ? ctl.entry : cell_entry[(g == 0) ? 0 : g - 1]),
			.prev_after((g == 0) ? 1'b0 : after[(g == 0) ? 0 : g - 1]),
			.next_entry((g == N - 1) ? cell_entry[g] : cell_entry[(g == N - 1) ? g : g + 1]),
			.entry(cell_entry[g]),
			.after(after[g])
		);
	end

	always_comb begin
		count_d = count_q;
		if (is_pop) begin
			if (empty) begin
				status_d = spq_pkg::ST_POP_EMPTY;
			end else begin
				status_d = spq_pkg::ST_POPPED;
				count_d = count_q - CW'(1);
			end
		end else begin
			if (full) begin
				status_d = spq_pkg::ST_INSERT_FULL;
			end else begin
				status_d = spq_pkg::ST_INSERTED;
				count_d = count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			total_q <= count_d;
			if (ctl.pop) begin
				popped_q <= cell_entry[0];
			end else begin
				popped_q <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign status = status_q;
	assign popped_score = popped_q.score;
	assign popped_tag = popped_q.tag;
	assign entry_total = 5'(total_q);

endmodule
`default_nettype wire

### design/spq_checker.sv
`default_nettype none
module spq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic [1:0] status,
	input wire logic signed [31:0] popped_score,
	input wire logic [15:0] popped_tag,
	input wire logic [4:0] entry_total
);

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> entry_total <= 5'(spq_pkg::CAPACITY))
		else $error("entry total beyond capacity");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == spq_pkg::ST_POP_EMPTY |-> entry_total == '0)
		else $error("pop on empty reported with stored entries");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == spq_pkg::ST_INSERT_FULL
		|-> entry_total == 5'(spq_pkg::CAPACITY))
		else $error("insert dropped while the queue was not full");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != spq_pkg::ST_POPPED
		|-> popped_score == '0 && popped_tag == '0)
		else $error("popped fields non-zero without a pop");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status)
		&& $stable(entry_total))
		else $error("result changed while stalled");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.status(status),
	.popped_score(popped_score),
	.popped_tag(popped_tag),
	.entry_total(entry_total)
);
`default_nettype wire
